/* rtl/bda_pkg.sv */
package bda_pkg;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CHECK,
        ST_SCAN_START,
        ST_SCAN,
        ST_SETTLE,
        ST_RESP
    } state_t;

    localparam logic [2:0] MODE_SET_AVAIL  = 3'd0;
    localparam logic [2:0] MODE_LOAD_MAX   = 3'd1;
    localparam logic [2:0] MODE_LOAD_ALLOC = 3'd2;
    localparam logic [2:0] MODE_QUERY      = 3'd3;
    localparam logic [2:0] MODE_REQUEST    = 3'd4;

    localparam logic [2:0] STAT_OK         = 3'd0;
    localparam logic [2:0] STAT_OVER_NEED  = 3'd1;
    localparam logic [2:0] STAT_OVER_AVAIL = 3'd2;
    localparam logic [2:0] STAT_UNSAFE     = 3'd3;
    localparam logic [2:0] STAT_NEG_NEED   = 3'd4;
    localparam logic [2:0] STAT_BAD_PROC   = 3'd5;
    localparam logic [2:0] STAT_ALLOC_OVER = 3'd6;

    localparam logic CFG_IDX_PROCS = 1'b0;
    localparam logic CFG_IDX_KINDS = 1'b1;

    // slices of one stored row
    localparam int ROW_MAX   = 0;
    localparam int ROW_ALLOC = 1;
    localparam int ROW_NEED  = 2;

    localparam int AMT_LANES = 8;
    localparam int AMT_W     = 16;
    localparam int PC_CFG_W  = 5;
    localparam int RC_CFG_W  = 4;

    typedef struct packed {
        logic [2:0] status;
        logic       safe;
        logic       released;
        logic [2:0] fail;
    } result_t;

endpackage

/* rtl/bda_row_mem.sv */
module bda_row_mem #(
    parameter int DEPTH = 16,
    parameter int AW    = 4,
    parameter int W     = 384
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          we,
    input  logic [AW-1:0] waddr,
    input  logic [W-1:0]  wdata,
    input  logic [AW-1:0] raddr,
    output logic [W-1:0]  rdata
);

    logic [W-1:0]     mem [DEPTH];
    logic [W-1:0]     q_reg;
    logic [DEPTH-1:0] valid_reg;
    logic             qv_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        q_reg <= mem[raddr];
    end

    // a row never written reads as zero
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
            qv_reg    <= 1'b0;
        end else begin
            if (we) begin
                valid_reg[waddr] <= 1'b1;
            end
            qv_reg <= valid_reg[raddr];
        end
    end

    assign rdata = qv_reg ? q_reg : '0;

endmodule

/* rtl/bda_engine.sv */
module bda_engine #(
    parameter int MP  = 16,
    parameter int MR  = 8,
    parameter int CW  = 16,
    parameter int PAW = 4,
    parameter int PCW = 5,
    parameter int RCW = 4
) (
    input  logic                                                aclk,
    input  logic                                                aresetn,
    input  logic                                                s_valid,
    output logic                                                s_ready,
    input  logic [2:0]                                          s_mode,
    input  logic [3:0]                                          s_process_id,
    input  logic [bda_pkg::AMT_LANES-1:0][bda_pkg::AMT_W-1:0]   s_amount,
    input  logic [bda_pkg::PC_CFG_W-1:0]                        cfg_procs,
    input  logic [bda_pkg::RC_CFG_W-1:0]                        cfg_kinds,
    input  logic                                                out_free,
    output logic                                                res_load,
    output bda_pkg::result_t                                    res,
    output logic                                                mem_we,
    output logic [PAW-1:0]                                      mem_waddr,
    output logic [3*MR*CW-1:0]                                  mem_wdata,
    output logic [PAW-1:0]                                      mem_raddr,
    input  logic [3*MR*CW-1:0]                                  mem_rdata
);
    import bda_pkg::*;

    typedef logic [MR-1:0][CW-1:0]        lanes_t;
    typedef logic [2:0][MR-1:0][CW-1:0]   row_t;

    state_t           state_reg, state_next;
    logic [2:0]       mode_reg;
    logic [3:0]       pid_reg;
    lanes_t           amt_reg, amt_in;
    lanes_t           avail_reg, old_avail_reg, work_reg;
    row_t             old_row_reg, new_row_reg, row_q;
    logic [MP-1:0]    fin_reg;
    logic [PCW-1:0]   done_reg;
    logic [PAW-1:0]   p_reg;
    logic             prog_reg;
    logic [2:0]       status_reg, fail_reg;
    logic             safe_reg, rel_reg;

    logic [PCW-1:0]   pc_eff;
    logic [RCW-1:0]   rc_eff;
    logic [MR-1:0]    en;
    logic [MR-1:0][CW+AMT_W-1:0] amt_ext;
    logic [PAW+3:0]   pid_in_ext, pid_reg_ext;
    logic [PAW-1:0]   pid_addr_in, pid_addr_reg;

    logic [MR-1:0]    f_neg, f_max, f_av6, f_need, f_av, f_req, f_low;
    lanes_t           alloc_av;
    logic [MR-1:0][CW:0] sum_aa;
    logic [MR-1:0][CW:0] left_aa;

    logic [2:0]       chk_status, chk_fail;
    logic             chk_we, chk_scan, bad;
    row_t             chk_row;
    lanes_t           chk_av;

    logic [MR-1:0]    need_fit;
    logic             fits, scan_last, scan_hit, scan_more;
    logic [PCW-1:0]   done_new;
    lanes_t           work_add;

    row_t             cur_row, set_row;
    lanes_t           cur_av, set_av;
    logic             all_zero;

    function automatic logic [CW-1:0] sat_add(input logic [CW-1:0] a, input logic [CW-1:0] b);
        logic [CW:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[CW] ? {CW{1'b1}} : s[CW-1:0];
    endfunction

    function automatic logic [2:0] first_idx(input logic [MR-1:0] v);
        logic [2:0] idx;
        idx = 3'd0;
        for (int r = MR - 1; r >= 0; r--) begin
            if (v[r]) idx = 3'(r);
        end
        return idx;
    endfunction

    // clamp the configured counts
    always_comb begin
        if (cfg_procs == '0) begin
            pc_eff = PCW'(1);
        end else if (int'(cfg_procs) > MP) begin
            pc_eff = PCW'(MP);
        end else begin
            pc_eff = PCW'(cfg_procs);
        end
        if (cfg_kinds == '0) begin
            rc_eff = RCW'(1);
        end else if (int'(cfg_kinds) > MR) begin
            rc_eff = RCW'(MR);
        end else begin
            rc_eff = RCW'(cfg_kinds);
        end
        for (int r = 0; r < MR; r++) begin
            en[r] = RCW'(r) < rc_eff;
        end
    end

    always_comb begin
        for (int r = 0; r < MR; r++) begin
            amt_ext[r] = {{CW{1'b0}}, s_amount[r]};
            amt_in[r]  = amt_ext[r][CW-1:0];
        end
    end

    assign pid_in_ext   = {{PAW{1'b0}}, s_process_id};
    assign pid_reg_ext  = {{PAW{1'b0}}, pid_reg};
    assign pid_addr_in  = pid_in_ext[PAW-1:0];
    assign pid_addr_reg = pid_reg_ext[PAW-1:0];
    assign row_q        = mem_rdata;

    // per-lane checks on the addressed row
    always_comb begin
        for (int r = 0; r < MR; r++) begin
            sum_aa[r]   = {1'b0, avail_reg[r]} + {1'b0, row_q[ROW_ALLOC][r]};
            left_aa[r]  = sum_aa[r] - {1'b0, amt_reg[r]};
            f_neg[r]    = en[r] && (amt_reg[r] < row_q[ROW_ALLOC][r]);
            f_max[r]    = en[r] && (amt_reg[r] > row_q[ROW_MAX][r]);
            f_av6[r]    = en[r] && ({1'b0, amt_reg[r]} > sum_aa[r]);
            f_need[r]   = en[r] && (amt_reg[r] > row_q[ROW_NEED][r]);
            f_av[r]     = en[r] && (amt_reg[r] > avail_reg[r]);
            alloc_av[r] = left_aa[r][CW] ? {CW{1'b1}} : left_aa[r][CW-1:0];
        end
        f_req = f_need | f_av;
        f_low = f_req & (~f_req + 1'b1);
    end

    always_comb begin
        chk_status = STAT_OK;
        chk_fail   = 3'd0;
        chk_we     = 1'b0;
        chk_scan   = 1'b0;
        chk_row    = row_q;
        chk_av     = avail_reg;
        bad = ((mode_reg == MODE_LOAD_MAX) || (mode_reg == MODE_LOAD_ALLOC)
               || (mode_reg == MODE_REQUEST))
              && ({{PCW{1'b0}}, pid_reg} >= {4'd0, pc_eff});
        if (bad) begin
            chk_status = STAT_BAD_PROC;
        end else begin
            case (mode_reg)
                MODE_SET_AVAIL: begin
                    for (int r = 0; r < MR; r++) begin
                        if (en[r]) chk_av[r] = amt_reg[r];
                    end
                end
                MODE_LOAD_MAX: begin
                    if (|f_neg) begin
                        chk_status = STAT_NEG_NEED;
                        chk_fail   = first_idx(f_neg);
                    end else begin
                        chk_we = 1'b1;
                        for (int r = 0; r < MR; r++) begin
                            if (en[r]) begin
                                chk_row[ROW_MAX][r]  = amt_reg[r];
                                chk_row[ROW_NEED][r] = amt_reg[r] - row_q[ROW_ALLOC][r];
                            end
                        end
                    end
                end
                MODE_LOAD_ALLOC: begin
                    if (|f_max) begin
                        chk_status = STAT_NEG_NEED;
                        chk_fail   = first_idx(f_max);
                    end else if (|f_av6) begin
                        chk_status = STAT_ALLOC_OVER;
                        chk_fail   = first_idx(f_av6);
                    end else begin
                        chk_we   = 1'b1;
                        chk_scan = 1'b1;
                        for (int r = 0; r < MR; r++) begin
                            if (en[r]) begin
                                chk_av[r]             = alloc_av[r];
                                chk_row[ROW_ALLOC][r] = amt_reg[r];
                                chk_row[ROW_NEED][r]  = row_q[ROW_MAX][r] - amt_reg[r];
                            end
                        end
                    end
                end
                MODE_QUERY: begin
                    chk_scan = 1'b1;
                end
                MODE_REQUEST: begin
                    if (|f_req) begin
                        chk_status = (|(f_need & f_low)) ? STAT_OVER_NEED : STAT_OVER_AVAIL;
                        chk_fail   = first_idx(f_req);
                    end else begin
                        // grant tentatively
                        chk_we   = 1'b1;
                        chk_scan = 1'b1;
                        for (int r = 0; r < MR; r++) begin
                            if (en[r]) begin
                                chk_av[r]             = avail_reg[r] - amt_reg[r];
                                chk_row[ROW_ALLOC][r] = row_q[ROW_ALLOC][r] + amt_reg[r];
                                chk_row[ROW_NEED][r]  = row_q[ROW_NEED][r] - amt_reg[r];
                            end
                        end
                    end
                end
                default: begin
                end
            endcase
        end
    end

    // one process per cycle during the safety scan
    always_comb begin
        for (int r = 0; r < MR; r++) begin
            need_fit[r] = !en[r] || (row_q[ROW_NEED][r] <= work_reg[r]);
            work_add[r] = sat_add(work_reg[r], row_q[ROW_ALLOC][r]);
        end
        fits      = !fin_reg[p_reg] && (&need_fit);
        done_new  = done_reg + PCW'(fits);
        scan_last = PCW'(p_reg) == (pc_eff - PCW'(1));
        scan_hit  = done_new == pc_eff;
        scan_more = prog_reg || fits;
    end

    // keep or roll back the grant, then release a finished process
    always_comb begin
        cur_row  = safe_reg ? new_row_reg : old_row_reg;
        cur_av   = safe_reg ? avail_reg : old_avail_reg;
        all_zero = 1'b1;
        for (int r = 0; r < MR; r++) begin
            if (en[r] && (cur_row[ROW_NEED][r] != '0)) all_zero = 1'b0;
        end
        set_row = cur_row;
        set_av  = cur_av;
        if (all_zero) begin
            for (int r = 0; r < MR; r++) begin
                if (en[r]) begin
                    set_av[r]             = sat_add(cur_av[r], cur_row[ROW_ALLOC][r]);
                    set_row[ROW_ALLOC][r] = '0;
                    set_row[ROW_NEED][r]  = '0;
                end
            end
        end
    end

    always_comb begin
        state_next = state_reg;
        s_ready    = 1'b0;
        res_load   = 1'b0;
        mem_we     = 1'b0;
        mem_waddr  = pid_addr_reg;
        mem_wdata  = chk_row;
        mem_raddr  = pid_addr_reg;
        case (state_reg)
            ST_IDLE: begin
                s_ready   = 1'b1;
                mem_raddr = pid_addr_in;
                if (s_valid) state_next = ST_CHECK;
            end
            ST_CHECK: begin
                mem_we     = chk_we;
                state_next = chk_scan ? ST_SCAN_START : ST_RESP;
            end
            ST_SCAN_START: begin
                mem_raddr  = '0;
                state_next = ST_SCAN;
            end
            ST_SCAN: begin
                mem_raddr = scan_last ? '0 : p_reg + 1'b1;
                if (scan_last && (scan_hit || !scan_more)) begin
                    state_next = (mode_reg == MODE_REQUEST) ? ST_SETTLE : ST_RESP;
                end
            end
            ST_SETTLE: begin
                mem_we     = 1'b1;
                mem_wdata  = set_row;
                state_next = ST_RESP;
            end
            ST_RESP: begin
                res_load = out_free;
                if (out_free) state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            avail_reg <= '0;
        end else begin
            state_reg <= state_next;
            if (state_reg == ST_CHECK) begin
                avail_reg <= chk_av;
            end else if (state_reg == ST_SETTLE) begin
                avail_reg <= set_av;
            end
        end
    end

    always_ff @(posedge aclk) begin
        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    mode_reg <= s_mode;
                    pid_reg  <= s_process_id;
                    amt_reg  <= amt_in;
                end
            end
            ST_CHECK: begin
                old_avail_reg <= avail_reg;
                old_row_reg   <= row_q;
                new_row_reg   <= chk_row;
                status_reg    <= chk_status;
                fail_reg      <= chk_fail;
                safe_reg      <= 1'b0;
                rel_reg       <= 1'b0;
            end
            ST_SCAN_START: begin
                work_reg <= avail_reg;
                fin_reg  <= '0;
                done_reg <= '0;
                p_reg    <= '0;
                prog_reg <= 1'b0;
            end
            ST_SCAN: begin
                if (fits) begin
                    fin_reg[p_reg] <= 1'b1;
                    work_reg       <= work_add;
                end
                done_reg <= done_new;
                if (scan_last) begin
                    p_reg    <= '0;
                    prog_reg <= 1'b0;
                    if (scan_hit) safe_reg <= 1'b1;
                end else begin
                    p_reg    <= p_reg + 1'b1;
                    prog_reg <= scan_more;
                end
            end
            ST_SETTLE: begin
                rel_reg <= all_zero;
                if (!safe_reg) status_reg <= STAT_UNSAFE;
            end
            default: begin
            end
        endcase
    end

    assign res.status   = status_reg;
    assign res.safe     = safe_reg;
    assign res.released = rel_reg;
    assign res.fail     = fail_reg;

endmodule

/* rtl/bankers_deadlock_avoidance.sv */
// Deadlock-avoidance engine for up to MAX_PROCESSES processes and
// MAX_RESOURCES resource kinds.
// Input channel (s_valid/s_ready): one word per command: mode, process_id
// and one row of amounts. Result channel (m_valid/m_ready): one word per
// command with status, safe, released and failing_resource.
// Config port: cfg_we with cfg_index 0 (process count) or 1 (resource kind
// count); the user must write it only while the block is idle, unchecked.
// Rows (max, allocation, need) live in one synchronous RAM, one row per
// process, read in the cycle after the address is given.
// Commands without a scan go through a check state and then the response state.
// Commands that run the safety scan make at most P passes, P the process
// count, and a request adds a settle state; the scan reads one process row per
// cycle through the RAM port.
// One command is in flight at a time; s_ready is high only while idle.
// A result held by m_ready low stays in the output register, and the next
// command may be accepted and worked on meanwhile.
// Reset clears available counts and marks every RAM row as zero; no
// clearing pass is needed.
module bankers_deadlock_avoidance #(
    parameter int MAX_PROCESSES = 16,
    parameter int MAX_RESOURCES = 8,
    parameter int COUNT_WIDTH   = 16
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [2:0]  s_mode,
    input  logic [3:0]  s_process_id,
    input  logic [15:0] s_amount_0,
    input  logic [15:0] s_amount_1,
    input  logic [15:0] s_amount_2,
    input  logic [15:0] s_amount_3,
    input  logic [15:0] s_amount_4,
    input  logic [15:0] s_amount_5,
    input  logic [15:0] s_amount_6,
    input  logic [15:0] s_amount_7,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [2:0]  m_status,
    output logic        m_safe,
    output logic        m_released,
    output logic [2:0]  m_failing_resource,
    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic [4:0]  cfg_wdata
);
    import bda_pkg::*;

    localparam int PAW   = (MAX_PROCESSES > 1) ? $clog2(MAX_PROCESSES) : 1;
    localparam int PCW   = $clog2(MAX_PROCESSES + 1);
    localparam int RCW   = $clog2(MAX_RESOURCES + 1);
    localparam int ROW_W = 3 * MAX_RESOURCES * COUNT_WIDTH;

    logic [AMT_LANES-1:0][AMT_W-1:0] amt_bus;
    logic [PC_CFG_W-1:0] procs_reg;
    logic [RC_CFG_W-1:0] kinds_reg;
    logic                m_valid_reg;
    result_t             out_reg, res;
    logic                res_load, out_free;
    logic                mem_we;
    logic [PAW-1:0]      mem_waddr, mem_raddr;
    logic [ROW_W-1:0]    mem_wdata, mem_rdata;

    assign amt_bus[0] = s_amount_0;
    assign amt_bus[1] = s_amount_1;
    assign amt_bus[2] = s_amount_2;
    assign amt_bus[3] = s_amount_3;
    assign amt_bus[4] = s_amount_4;
    assign amt_bus[5] = s_amount_5;
    assign amt_bus[6] = s_amount_6;
    assign amt_bus[7] = s_amount_7;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            procs_reg <= 5'd16;
            kinds_reg <= 4'd8;
        end else if (cfg_we) begin
            case (cfg_index)
                CFG_IDX_PROCS: procs_reg <= cfg_wdata;
                CFG_IDX_KINDS: kinds_reg <= cfg_wdata[RC_CFG_W-1:0];
                default: begin
                end
            endcase
        end
    end

    bda_row_mem #(
        .DEPTH (MAX_PROCESSES),
        .AW    (PAW),
        .W     (ROW_W)
    ) u_mem (
        .aclk    (aclk),
        .aresetn (aresetn),
        .we      (mem_we),
        .waddr   (mem_waddr),
        .wdata   (mem_wdata),
        .raddr   (mem_raddr),
        .rdata   (mem_rdata)
    );

    bda_engine #(
        .MP  (MAX_PROCESSES),
        .MR  (MAX_RESOURCES),
        .CW  (COUNT_WIDTH),
        .PAW (PAW),
        .PCW (PCW),
        .RCW (RCW)
    ) u_engine (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_mode       (s_mode),
        .s_process_id (s_process_id),
        .s_amount     (amt_bus),
        .cfg_procs    (procs_reg),
        .cfg_kinds    (kinds_reg),
        .out_free     (out_free),
        .res_load     (res_load),
        .res          (res),
        .mem_we       (mem_we),
        .mem_waddr    (mem_waddr),
        .mem_wdata    (mem_wdata),
        .mem_raddr    (mem_raddr),
        .mem_rdata    (mem_rdata)
    );

    // output word register
    assign out_free = !m_valid_reg || m_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (res_load) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (res_load) out_reg <= res;
    end

    assign m_valid            = m_valid_reg;
    assign m_status           = out_reg.status;
    assign m_safe             = out_reg.safe;
    assign m_released         = out_reg.released;
    assign m_failing_resource = out_reg.fail;

endmodule

/* rtl/bda_checker.sv */
module bda_props (
    input logic       aclk,
    input logic       aresetn,
    input logic       s_valid,
    input logic       s_ready,
    input logic       m_valid,
    input logic       m_ready,
    input logic [2:0] m_status,
    input logic       m_safe,
    input logic       m_released,
    input logic [2:0] m_failing_resource
);
    import bda_pkg::*;

    // a held result word stays put
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_status) && $stable(m_safe)
        && $stable(m_released) && $stable(m_failing_resource))
        else $error("result word changed while stalled");

    a_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("second word taken while a command is in flight");

    a_safe_ok: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_safe |-> m_status == STAT_OK)
        else $error("safe flagged on a rejected command");

    a_release: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_released |-> m_status == STAT_OK || m_status == STAT_UNSAFE)
        else $error("release on a rejected request");

    a_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_status != 3'd7)
        else $error("undefined status code");

endmodule

bind bankers_deadlock_avoidance bda_props u_bda_checker (.*);

/* dv/bda_checker.sv */
`timescale 1ns / 100ps

module bda_checker (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    input  logic              s_ready,
    input  logic [2:0]        s_mode,
    input  logic [3:0]        s_process_id,
    input  logic [7:0][15:0]  s_amount,
    input  logic              m_valid,
    input  logic              m_ready,
    input  logic [2:0]        m_status,
    input  logic              m_safe,
    input  logic              m_released,
    input  logic [2:0]        m_failing_resource,
    input  logic              cfg_we,
    input  logic              cfg_index,
    input  logic [4:0]        cfg_wdata,
    output int                errors,
    output int                pending
);
    import bda_pkg::*;

    localparam int NPROC = 16;
    localparam int NKIND = 8;

    logic [4:0]  proc_reg;
    logic [3:0]  kind_reg;
    logic [15:0] avail_cnt [NKIND];
    logic [15:0] max_row   [NPROC][NKIND];
    logic [15:0] alloc_row [NPROC][NKIND];
    logic [15:0] need_row  [NPROC][NKIND];
    result_t     outcome_q [$];

    function automatic int procs_in_use();
        if (proc_reg == 0) return 1;
        return (proc_reg > NPROC) ? NPROC : int'(proc_reg);
    endfunction

    function automatic int kinds_in_use();
        if (kind_reg == 0) return 1;
        return (kind_reg > NKIND) ? NKIND : int'(kind_reg);
    endfunction

    function automatic logic [15:0] sat_add(logic [15:0] x, logic [15:0] y);
        logic [16:0] s;
        s = {1'b0, x} + {1'b0, y};
        return s[16] ? 16'hffff : s[15:0];
    endfunction

    // look for a completion order over the processes in use
    function automatic logic find_order();
        logic [15:0] work [NKIND];
        logic        fin  [NPROC];
        int          pc, rc, done;
        logic        progress, fits;
        pc = procs_in_use();
        rc = kinds_in_use();
        done = 0;
        for (int r = 0; r < NKIND; r++) work[r] = avail_cnt[r];
        for (int p = 0; p < NPROC; p++) fin[p] = 1'b0;
        for (int pass = 0; pass < pc && done < pc; pass++) begin
            progress = 1'b0;
            for (int p = 0; p < pc; p++) begin
                if (!fin[p]) begin
                    fits = 1'b1;
                    for (int r = 0; r < rc; r++)
                        if (need_row[p][r] > work[r]) fits = 1'b0;
                    if (fits) begin
                        fin[p] = 1'b1;
                        for (int r = 0; r < rc; r++)
                            work[r] = sat_add(work[r], alloc_row[p][r]);
                        done++;
                        progress = 1'b1;
                    end
                end
            end
            if (!progress) break;
        end
        return done == pc;
    endfunction

    function automatic result_t predict_outcome(logic [2:0] md, logic [3:0] pid,
                                                logic [7:0][15:0] a);
        result_t     res;
        int          pc, rc;
        logic        all_zero;
        logic [16:0] adj;
        res = '0;
        pc = procs_in_use();
        rc = kinds_in_use();
        if ((md == MODE_LOAD_MAX || md == MODE_LOAD_ALLOC || md == MODE_REQUEST)
                && pid >= pc) begin
            res.status = STAT_BAD_PROC;
        end else if (md == MODE_SET_AVAIL) begin
            for (int r = 0; r < rc; r++) avail_cnt[r] = a[r];
        end else if (md == MODE_LOAD_MAX) begin
            for (int r = 0; r < rc; r++)
                if (res.status == STAT_OK && a[r] < alloc_row[pid][r]) begin
                    res.status = STAT_NEG_NEED;
                    res.fail = r[2:0];
                end
            if (res.status == STAT_OK)
                for (int r = 0; r < rc; r++) begin
                    max_row[pid][r] = a[r];
                    need_row[pid][r] = a[r] - alloc_row[pid][r];
                end
        end else if (md == MODE_LOAD_ALLOC) begin
            for (int r = 0; r < rc; r++)
                if (res.status == STAT_OK && a[r] > max_row[pid][r]) begin
                    res.status = STAT_NEG_NEED;
                    res.fail = r[2:0];
                end
            for (int r = 0; r < rc; r++)
                if (res.status == STAT_OK &&
                        {1'b0, a[r]} > {1'b0, avail_cnt[r]} + {1'b0, alloc_row[pid][r]}) begin
                    res.status = STAT_ALLOC_OVER;
                    res.fail = r[2:0];
                end
            if (res.status == STAT_OK) begin
                for (int r = 0; r < rc; r++) begin
                    adj = {1'b0, avail_cnt[r]} + {1'b0, alloc_row[pid][r]} - {1'b0, a[r]};
                    avail_cnt[r] = adj[16] ? 16'hffff : adj[15:0];
                    alloc_row[pid][r] = a[r];
                    need_row[pid][r] = max_row[pid][r] - a[r];
                end
                res.safe = find_order();
            end
        end else if (md == MODE_QUERY) begin
            res.safe = find_order();
        end else if (md == MODE_REQUEST) begin
            for (int r = 0; r < rc; r++)
                if (res.status == STAT_OK) begin
                    if (a[r] > need_row[pid][r]) begin
                        res.status = STAT_OVER_NEED;
                        res.fail = r[2:0];
                    end else if (a[r] > avail_cnt[r]) begin
                        res.status = STAT_OVER_AVAIL;
                        res.fail = r[2:0];
                    end
                end
            if (res.status == STAT_OK) begin
                for (int r = 0; r < rc; r++) begin
                    avail_cnt[r] -= a[r];
                    alloc_row[pid][r] += a[r];
                    need_row[pid][r] -= a[r];
                end
                if (find_order()) begin
                    res.safe = 1'b1;
                end else begin
                    res.status = STAT_UNSAFE;
                    for (int r = 0; r < rc; r++) begin
                        avail_cnt[r] += a[r];
                        alloc_row[pid][r] -= a[r];
                        need_row[pid][r] += a[r];
                    end
                end
                all_zero = 1'b1;
                for (int r = 0; r < rc; r++)
                    if (need_row[pid][r] != 0) all_zero = 1'b0;
                if (all_zero) begin
                    for (int r = 0; r < rc; r++) begin
                        avail_cnt[r] = sat_add(avail_cnt[r], alloc_row[pid][r]);
                        alloc_row[pid][r] = '0;
                        need_row[pid][r] = '0;
                    end
                    res.released = 1'b1;
                end
            end
        end
        return res;
    endfunction

    always @(posedge aclk) begin
        result_t exp_w;
        if (!aresetn) begin
            proc_reg <= 5'd16;
            kind_reg <= 4'd8;
            for (int r = 0; r < NKIND; r++) avail_cnt[r] = '0;
            for (int p = 0; p < NPROC; p++)
                for (int r = 0; r < NKIND; r++) begin
                    max_row[p][r] = '0;
                    alloc_row[p][r] = '0;
                    need_row[p][r] = '0;
                end
            outcome_q.delete();
            errors <= 0;
            pending <= 0;
        end else begin
            if (cfg_we) begin
                if (cfg_index == CFG_IDX_PROCS) proc_reg <= cfg_wdata;
                else kind_reg <= cfg_wdata[3:0];
            end
            // compare the returned word before queuing a new prediction
            if (m_valid && m_ready) begin
                if (outcome_q.size() == 0) begin
                    $error("result word with nothing expected");
                    errors <= errors + 1;
                end else begin
                    exp_w = outcome_q.pop_front();
                    if (m_status !== exp_w.status)
                        $error("status: expected %0d, got %0d", exp_w.status, m_status);
                    if (m_safe !== exp_w.safe)
                        $error("safe: expected %0d, got %0d", exp_w.safe, m_safe);
                    if (m_released !== exp_w.released)
                        $error("released: expected %0d, got %0d",
                               exp_w.released, m_released);
                    if (m_failing_resource !== exp_w.fail)
                        $error("failing_resource: expected %0d, got %0d",
                               exp_w.fail, m_failing_resource);
                    if (m_status !== exp_w.status || m_safe !== exp_w.safe ||
                            m_released !== exp_w.released ||
                            m_failing_resource !== exp_w.fail)
                        errors <= errors + 1;
                end
            end
            if (s_valid && s_ready)
                outcome_q.push_back(predict_outcome(s_mode, s_process_id, s_amount));
            pending <= outcome_q.size();
        end
    end

endmodule

/* dv/tb.sv */
`timescale 1ns / 100ps

module tb;
    import bda_pkg::*;

    localparam int STALL_LIMIT = 20000;
    localparam int ITEMS_PER_PHASE = 210;

    logic             aclk = 1'b0;
    logic             aresetn = 1'b0;
    logic             s_valid = 1'b0;
    logic             s_ready;
    logic [2:0]       s_mode = '0;
    logic [3:0]       s_process_id = '0;
    logic [7:0][15:0] s_amount = '0;
    logic             m_valid;
    logic             m_ready = 1'b0;
    logic [2:0]       m_status;
    logic             m_safe;
    logic             m_released;
    logic [2:0]       m_failing_resource;
    logic             cfg_we = 1'b0;
    logic             cfg_index = 1'b0;
    logic [4:0]       cfg_wdata = '0;
    int               errors, pending;
    int               sender_idle_pct = 0;
    int               receiver_idle_pct = 0;
    logic             long_hold = 1'b0;
    int               words_sent = 0;
    int               settings_run = 0;
    int               quiet_cycles = 0;

    always #6 aclk = ~aclk;

    bankers_deadlock_avoidance i_dut (
        .aclk, .aresetn, .s_valid, .s_ready, .s_mode, .s_process_id,
        .s_amount_0(s_amount[0]), .s_amount_1(s_amount[1]),
        .s_amount_2(s_amount[2]), .s_amount_3(s_amount[3]),
        .s_amount_4(s_amount[4]), .s_amount_5(s_amount[5]),
        .s_amount_6(s_amount[6]), .s_amount_7(s_amount[7]),
        .m_valid, .m_ready, .m_status, .m_safe, .m_released, .m_failing_resource,
        .cfg_we, .cfg_index, .cfg_wdata
    );

    bda_checker i_checker (
        .aclk, .aresetn, .s_valid, .s_ready, .s_mode, .s_process_id, .s_amount,
        .m_valid, .m_ready, .m_status, .m_safe, .m_released, .m_failing_resource,
        .cfg_we, .cfg_index, .cfg_wdata, .errors, .pending
    );

    // receiver: random back-pressure, or one long hold-off when asked
    always @(posedge aclk) begin
        if (long_hold) begin
            m_ready <= 1'b0;
            for (int i = 0; i < 300; i++) @(posedge aclk);
            long_hold <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(99) >= receiver_idle_pct);
        end
    end

    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || !aresetn)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("status: fail");
            $finish;
        end
    end

    task automatic send_word(logic [2:0] md, logic [3:0] pid, logic [7:0][15:0] a);
        while ($urandom_range(99) < sender_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_mode <= md;
        s_process_id <= pid;
        s_amount <= a;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        words_sent++;
    endtask

    task automatic send_flat(logic [2:0] md, logic [3:0] pid, logic [15:0] v);
        send_word(md, pid, {8{v}});
    endtask

    // hold the input until every result is back
    task automatic drain();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (pending != 0 || s_valid) @(posedge aclk);
        repeat (8) @(posedge aclk);
    endtask

    task automatic write_setting(logic [4:0] procs, logic [3:0] kinds);
        drain();
        cfg_we <= 1'b1;
        cfg_index <= CFG_IDX_PROCS;
        cfg_wdata <= procs;
        @(posedge aclk);
        cfg_index <= CFG_IDX_KINDS;
        cfg_wdata <= {1'b0, kinds};
        @(posedge aclk);
        cfg_we <= 1'b0;
        @(posedge aclk);
        settings_run++;
    endtask

    function automatic logic [15:0] pick_amount(logic [2:0] md);
        if ($urandom_range(9) == 0) return 16'($urandom);
        case (md)
            MODE_SET_AVAIL:  return 16'($urandom_range(60));
            MODE_LOAD_MAX:   return 16'($urandom_range(30));
            MODE_LOAD_ALLOC: return 16'($urandom_range(8));
            default:         return 16'($urandom_range(4));
        endcase
    endfunction

    task automatic random_word(int pc);
        logic [2:0]       md;
        logic [3:0]       pid;
        logic [7:0][15:0] a;
        int               roll;
        roll = $urandom_range(99);
        if (roll < 10)      md = MODE_SET_AVAIL;
        else if (roll < 28) md = MODE_LOAD_MAX;
        else if (roll < 46) md = MODE_LOAD_ALLOC;
        else if (roll < 56) md = MODE_QUERY;
        else if (roll < 95) md = MODE_REQUEST;
        else                md = 3'($urandom_range(7, 5));
        pid = ($urandom_range(9) == 0) ? 4'($urandom) : 4'($urandom_range(pc - 1));
        for (int r = 0; r < 8; r++) a[r] = pick_amount(md);
        send_word(md, pid, a);
    endtask

    task automatic random_phase(int pc);
        for (int i = 0; i < ITEMS_PER_PHASE; i++) begin
            if (i == 60) long_hold <= 1'b1;
            if (i == 120) drain();
            random_word(pc);
        end
    endtask

    initial begin
        logic [7:0][15:0] v;
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        sender_idle_pct = 6;
        receiver_idle_pct = 80;

        // directed: reset state, unused modes, field extremes, each status but bad process
        send_flat(MODE_QUERY, 4'd0, 16'd0);
        send_flat(3'd5, 4'd15, 16'hffff);
        send_flat(3'd6, 4'd3, 16'h0);
        send_flat(3'd7, 4'd9, 16'haaaa);
        send_flat(MODE_SET_AVAIL, 4'd0, 16'hffff);
        send_flat(MODE_LOAD_MAX, 4'd0, 16'hffff);
        send_flat(MODE_LOAD_ALLOC, 4'd0, 16'hffff);
        send_flat(MODE_LOAD_MAX, 4'd15, 16'h0);
        send_flat(MODE_REQUEST, 4'd1, 16'd1);
        send_flat(MODE_LOAD_MAX, 4'd0, 16'd0);
        send_flat(MODE_LOAD_ALLOC, 4'd0, 16'd0);
        send_flat(MODE_SET_AVAIL, 4'd0, 16'd10);
        send_flat(MODE_LOAD_MAX, 4'd2, 16'd5);
        send_flat(MODE_REQUEST, 4'd2, 16'd5);
        send_flat(MODE_LOAD_MAX, 4'd3, 16'd50);
        send_flat(MODE_REQUEST, 4'd3, 16'd20);
        send_flat(MODE_LOAD_ALLOC, 4'd3, 16'd40);
        send_flat(MODE_LOAD_MAX, 4'd3, 16'd0);
        send_flat(MODE_LOAD_MAX, 4'd4, 16'd10);
        send_flat(MODE_LOAD_MAX, 4'd5, 16'd10);
        send_flat(MODE_LOAD_ALLOC, 4'd4, 16'd3);
        send_flat(MODE_LOAD_ALLOC, 4'd5, 16'd3);
        send_flat(MODE_REQUEST, 4'd4, 16'd2);
        v = '0;
        v[7] = 16'd1;
        send_word(MODE_REQUEST, 4'd5, v);
        send_flat(MODE_QUERY, 4'd15, 16'h5555);

        random_phase(16);
        write_setting(5'd1, 4'd1);
        random_phase(1);
        write_setting(5'd0, 4'd0);
        random_phase(1);

        sender_idle_pct = 80;
        receiver_idle_pct = 6;
        write_setting(5'd31, 4'd15);
        random_phase(16);
        write_setting(5'd4, 4'd3);
        random_phase(4);

        sender_idle_pct = 0;
        receiver_idle_pct = 0;
        write_setting(5'd16, 4'd8);
        random_phase(16);
        write_setting(5'(1 + $urandom_range(15)), 4'(1 + $urandom_range(7)));
        random_phase(16);

        drain();
        repeat (20) @(posedge aclk);
        $display("covered %0d command words over %0d register settings,", words_sent,
                 settings_run + 1);
        $display("with skewed back-pressure, a long output stall and idle pauses");
        if (errors == 0 && pending == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
